// ===== rtl/kfm_pkg.sv =====
// kfm_pkg: shared types, constants and the Feistel round function of the keyed MAC.
// Used by keyed_feistel_mac; no dependencies.
`timescale 1ns / 1ps

package kfm_pkg;

   localparam int STATE_BYTES = 32;
   localparam int HALF_BYTES  = 16;

   typedef logic [STATE_BYTES-1:0][7:0] chain_type;
   typedef logic [3:0][63:0]            key_type;

   typedef enum logic [2:0] {
      ST_KEYGEN,
      ST_IDLE,
      ST_ROUND,
      ST_LENXOR,
      ST_FIN,
      ST_OUT
   } state_type;

   // register indexes on the csr port
   localparam logic [2:0] CSR_KEY_A      = 3'd0;
   localparam logic [2:0] CSR_KEY_B      = 3'd1;
   localparam logic [2:0] CSR_KEY_C      = 3'd2;
   localparam logic [2:0] CSR_KEY_D      = 3'd3;
   localparam logic [2:0] CSR_KEY_LENGTH = 3'd4;
   localparam logic [2:0] CSR_ROUNDS     = 3'd5;
   localparam logic [2:0] CSR_TAG_LENGTH = 3'd6;

   localparam logic [6:0] KEY_LENGTH_RST = 7'd32;
   localparam logic [3:0] ROUNDS_RST     = 4'd8;
   localparam logic [5:0] TAG_LENGTH_RST = 6'd32;

   localparam logic [7:0] AND_TAB [32] = '{
      8'hB7, 8'h5D, 8'hA3, 8'hE1, 8'h97, 8'h4F, 8'hC5, 8'h2B,
      8'h8D, 8'h61, 8'hF3, 8'h1F, 8'hD9, 8'h73, 8'h3D, 8'hAF,
      8'h17, 8'h89, 8'hCB, 8'h53, 8'hE7, 8'h2D, 8'h9B, 8'h41,
      8'hBB, 8'h6D, 8'hF1, 8'h23, 8'hDD, 8'h7F, 8'h35, 8'hA9
   };

   localparam logic [7:0] OR_TAB [32] = '{
      8'h11, 8'h22, 8'h44, 8'h08, 8'h10, 8'h21, 8'h42, 8'h04,
      8'h12, 8'h24, 8'h48, 8'h09, 8'h14, 8'h28, 8'h41, 8'h02,
      8'h18, 8'h30, 8'h60, 8'h05, 8'h0A, 8'h15, 8'h2A, 8'h54,
      8'h19, 8'h32, 8'h64, 8'h06, 8'h0C, 8'h19, 8'h33, 8'h66
   };

   function automatic logic [7:0] rotl8(logic [7:0] x, logic [2:0] s);
      logic [15:0] w;
      w = {x, x} << s;
      return w[15:8];
   endfunction

   function automatic logic [7:0] key_byte(key_type kw, logic [4:0] j);
      return kw[j[4:3]][{j[2:0], 3'b000} +: 8];
   endfunction

   // One Feistel round; ck holds the key already cycled to the key length.
   function automatic chain_type feistel_round(chain_type chain, chain_type ck,
                                               logic [4:0] rnd);
      logic [127:0] r_vec;
      logic [255:0] dbl;
      logic [127:0] r_rot;
      logic [3:0]   sh;
      logic [7:0]   k;
      logic [7:0]   x;
      logic [4:0]   ai;
      logic [4:0]   oi;
      chain_type    nxt;
      r_vec = chain[31:16];
      sh    = rnd[3:0] + 4'd1;
      dbl   = {r_vec, r_vec} >> {sh, 3'b000};
      r_rot = dbl[127:0];
      for (int i = 0; i < HALF_BYTES; i++) begin
         k  = ck[i];
         x  = rotl8(r_vec[8*i +: 8] ^ k, rnd[2:0] + 3'(i));
         ai = 5'(i) + rnd * 5'd7;
         oi = 5'(i) + rnd * 5'd11;
         x  = (x & AND_TAB[ai]) | OR_TAB[oi];
         x  = x ^ r_rot[8*i +: 8];
         nxt[i]      = r_vec[8*i +: 8];
         nxt[16 + i] = chain[i] ^ x ^ k;
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/keyed_feistel_mac.sv =====
// keyed_feistel_mac: keyed byte-stream MAC built on a shared Feistel round unit.
// Depends on kfm_pkg (types, tables, round function).
`timescale 1ns / 1ps

// Usage
//   req_*: one message byte per transaction (req_has_byte), req_last ends the
//   message. A transaction with neither flag set is dropped.
//   rsp_*: the tag, one byte per transaction, rsp_tag_last on the final one.
//   csr_*: register writes, taken at once; user writes only between transactions.
// Timing
//   A byte is absorbed as it is taken. A byte that fills the 32-byte block adds
//   round_count Feistel rounds, one round per cycle in the single round unit.
//   A last transaction adds round_count rounds for a partial block, the length
//   fold and round_count finalization rounds, then min(tag_length, 32) tag bytes
//   at full rate unless rsp_ready stalls them.
//   req_ready is low while rounds run and while the tag is sent.
// Reset and configuration
//   After reset and after each csr write the key is expanded to 32 bytes, one
//   byte per cycle: req_ready stays low until the expansion is done.
// Stall
//   A stalled tag byte holds rsp_* unchanged; nothing but csr writes moves meanwhile.
module keyed_feistel_mac (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tag_byte,
   output logic        rsp_tag_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   kfm_pkg::state_type state_ff, state_in;
   kfm_pkg::key_type   key_ff;
   logic [6:0]         klen_ff;
   logic [3:0]         rcount_ff;
   logic [5:0]         tlen_ff;
   logic               cfg_pend_ff, cfg_pend_in;

   kfm_pkg::chain_type ck_ff, ck_in;
   kfm_pkg::chain_type chain_ff, chain_in;
   logic [4:0]         fill_ff, fill_in;
   logic [63:0]        len_ff, len_in;
   logic               in_msg_ff, in_msg_in;
   logic               last_pend_ff, last_pend_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [4:0]         rnd_ff, rnd_in;
   logic [4:0]         gen_idx_ff, gen_idx_in;
   logic [4:0]         gen_j_ff, gen_j_in;
   logic [4:0]         out_idx_ff, out_idx_in;

   logic [5:0]         klen_eff;
   logic [5:0]         tag_n;
   logic [4:0]         tag_last_idx;
   logic               req_fire;
   logic               rsp_fire;
   logic               rounds_done;
   kfm_pkg::chain_type round_out;
   kfm_pkg::chain_type absorb_base;
   logic [4:0]         fill_base;
   logic [5:0]         fill_next;
   logic [63:0]        len_base;
   logic               full_block;

   assign klen_eff = (klen_ff == 7'd0 || klen_ff > 7'd32) ? 6'd32 : klen_ff[5:0];
   assign tag_n    = (tlen_ff > 6'd32) ? 6'd32 : tlen_ff;
   assign tag_last_idx = 5'(tag_n - 6'd1);

   assign req_ready    = (state_ff == kfm_pkg::ST_IDLE) && !cfg_pend_ff;
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid    = (state_ff == kfm_pkg::ST_OUT);
   assign rsp_fire     = rsp_valid && rsp_ready;
   assign rsp_tag_byte = chain_ff[out_idx_ff];
   assign rsp_tag_last = (out_idx_ff == tag_last_idx);

   assign round_out   = kfm_pkg::feistel_round(chain_ff, ck_ff, rnd_ff);
   assign rounds_done = (cnt_ff == rcount_ff - 4'd1);

   // a new message starts from the cycled key
   assign absorb_base = in_msg_ff ? chain_ff : ck_ff;
   assign fill_base   = in_msg_ff ? fill_ff : 5'd0;
   assign len_base    = in_msg_ff ? len_ff : 64'd0;
   assign fill_next   = {1'b0, fill_base} + 6'd1;
   assign full_block  = req_has_byte && (fill_next == 6'd32);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         klen_ff   <= kfm_pkg::KEY_LENGTH_RST;
         rcount_ff <= kfm_pkg::ROUNDS_RST;
         tlen_ff   <= kfm_pkg::TAG_LENGTH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            kfm_pkg::CSR_KEY_A:      key_ff[0] <= csr_wdata;
            kfm_pkg::CSR_KEY_B:      key_ff[1] <= csr_wdata;
            kfm_pkg::CSR_KEY_C:      key_ff[2] <= csr_wdata;
            kfm_pkg::CSR_KEY_D:      key_ff[3] <= csr_wdata;
            kfm_pkg::CSR_KEY_LENGTH: klen_ff   <= csr_wdata[6:0];
            kfm_pkg::CSR_ROUNDS:     rcount_ff <= csr_wdata[3:0];
            kfm_pkg::CSR_TAG_LENGTH: tlen_ff   <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kfm_pkg::ST_KEYGEN;
         cfg_pend_ff  <= 1'b0;
         fill_ff      <= '0;
         len_ff       <= '0;
         in_msg_ff    <= 1'b0;
         last_pend_ff <= 1'b0;
         cnt_ff       <= '0;
         rnd_ff       <= '0;
         gen_idx_ff   <= '0;
         gen_j_ff     <= '0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cfg_pend_ff  <= cfg_pend_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         in_msg_ff    <= in_msg_in;
         last_pend_ff <= last_pend_in;
         cnt_ff       <= cnt_in;
         rnd_ff       <= rnd_in;
         gen_idx_ff   <= gen_idx_in;
         gen_j_ff     <= gen_j_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ck_ff    <= ck_in;
      chain_ff <= chain_in;
   end

   always_comb begin
      state_in     = state_ff;
      cfg_pend_in  = cfg_pend_ff | csr_we;
      ck_in        = ck_ff;
      chain_in     = chain_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      in_msg_in    = in_msg_ff;
      last_pend_in = last_pend_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      gen_idx_in   = gen_idx_ff;
      gen_j_in     = gen_j_ff;
      out_idx_in   = out_idx_ff;

      unique case (state_ff)
         kfm_pkg::ST_KEYGEN: begin
            if (cfg_pend_ff) begin
               // restart the expansion with the new register values
               cfg_pend_in = csr_we;
               gen_idx_in  = '0;
               gen_j_in    = '0;
            end else begin
               ck_in[gen_idx_ff] = kfm_pkg::key_byte(key_ff, gen_j_ff);
               gen_idx_in = gen_idx_ff + 5'd1;
               gen_j_in   = ({1'b0, gen_j_ff} + 6'd1 == klen_eff) ? 5'd0 : gen_j_ff + 5'd1;
               if (gen_idx_ff == 5'd31) begin
                  state_in = kfm_pkg::ST_IDLE;
               end
            end
         end
         kfm_pkg::ST_IDLE: begin
            if (cfg_pend_ff) begin
               state_in    = kfm_pkg::ST_KEYGEN;
               cfg_pend_in = csr_we;
               gen_idx_in  = '0;
               gen_j_in    = '0;
            end else if (req_fire && (req_has_byte || req_last)) begin
               chain_in     = absorb_base;
               fill_in      = fill_base;
               len_in       = len_base;
               in_msg_in    = 1'b1;
               last_pend_in = req_last;
               cnt_in       = '0;
               rnd_in       = '0;
               if (req_has_byte) begin
                  chain_in[fill_base] = absorb_base[fill_base] ^ req_data_byte;
                  fill_in = fill_next[4:0];
                  len_in  = len_base + 64'd1;
               end
               if ((full_block || (req_last && fill_in != 5'd0)) && rcount_ff != 4'd0) begin
                  state_in = kfm_pkg::ST_ROUND;
               end else if (req_last) begin
                  state_in = kfm_pkg::ST_LENXOR;
               end
            end
         end
         kfm_pkg::ST_ROUND: begin
            chain_in = round_out;
            cnt_in   = cnt_ff + 4'd1;
            rnd_in   = rnd_ff + 5'd1;
            if (rounds_done) begin
               fill_in  = '0;
               state_in = last_pend_ff ? kfm_pkg::ST_LENXOR : kfm_pkg::ST_IDLE;
            end
         end
         kfm_pkg::ST_LENXOR: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] ^ len_ff[8*(7-i) +: 8];
            end
            fill_in    = '0;
            len_in     = '0;
            in_msg_in  = 1'b0;
            cnt_in     = '0;
            rnd_in     = {1'b0, rcount_ff};
            out_idx_in = '0;
            if (rcount_ff != 4'd0) begin
               state_in = kfm_pkg::ST_FIN;
            end else begin
               state_in = (tag_n != 6'd0) ? kfm_pkg::ST_OUT : kfm_pkg::ST_IDLE;
            end
         end
         kfm_pkg::ST_FIN: begin
            chain_in = round_out;
            cnt_in   = cnt_ff + 4'd1;
            rnd_in   = rnd_ff + 5'd1;
            if (rounds_done) begin
               state_in = (tag_n != 6'd0) ? kfm_pkg::ST_OUT : kfm_pkg::ST_IDLE;
            end
         end
         kfm_pkg::ST_OUT: begin
            if (rsp_fire) begin
               out_idx_in = out_idx_ff + 5'd1;
               if (rsp_tag_last) begin
                  state_in = kfm_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = kfm_pkg::ST_IDLE;
      endcase
   end

   // the two channels never run at once
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and tag channels active together");

   // the final tag byte closes the tag run
   a_tag_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_tag_last |=> !rsp_valid)
      else $error("tag output continues past the final byte");

   // the tag index never passes the tag length
   a_tag_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (tag_n != 6'd0) && ({1'b0, out_idx_ff} < tag_n))
      else $error("tag index out of range");

   // the length fold clears the open-message flag and the length
   a_lenxor_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == kfm_pkg::ST_LENXOR |=> !in_msg_ff && len_ff == 64'd0)
      else $error("message state not cleared at finalization");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking regression for keyed_feistel_mac (tag prediction, handshake stress).
// Depends on kfm_pkg for the csr register indexes; drives rtl/keyed_feistel_mac.sv.
`timescale 1ns / 1ps

module tb_top;

   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 32;

   localparam logic [0:31][7:0] AND_MASK = {
      8'hB7, 8'h5D, 8'hA3, 8'hE1, 8'h97, 8'h4F, 8'hC5, 8'h2B,
      8'h8D, 8'h61, 8'hF3, 8'h1F, 8'hD9, 8'h73, 8'h3D, 8'hAF,
      8'h17, 8'h89, 8'hCB, 8'h53, 8'hE7, 8'h2D, 8'h9B, 8'h41,
      8'hBB, 8'h6D, 8'hF1, 8'h23, 8'hDD, 8'h7F, 8'h35, 8'hA9
   };
   localparam logic [0:31][7:0] OR_MASK = {
      8'h11, 8'h22, 8'h44, 8'h08, 8'h10, 8'h21, 8'h42, 8'h04,
      8'h12, 8'h24, 8'h48, 8'h09, 8'h14, 8'h28, 8'h41, 8'h02,
      8'h18, 8'h30, 8'h60, 8'h05, 8'h0A, 8'h15, 8'h2A, 8'h54,
      8'h19, 8'h32, 8'h64, 8'h06, 8'h0C, 8'h19, 8'h33, 8'h66
   };

   typedef struct packed {
      logic [7:0] tag;
      logic       last;
   } tag_beat_type;

   typedef enum logic {ROW_REG, ROW_ITEM} row_kind_type;

   // typed: expected tag byte i in bits 8*i, used for the first n_typed bytes
   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   index;
      logic [63:0]  value;
      logic [7:0]   data;
      logic         has;
      logic         last;
      int           n_typed;
      logic [63:0]  typed;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_tag_byte;
   logic        rsp_tag_last;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   // predictor copy of the registers and the MAC state
   logic [63:0] cfg_key [4];
   logic [6:0]  cfg_key_len;
   logic [3:0]  cfg_rounds;
   logic [5:0]  cfg_tag_len;
   logic [7:0]  mac_chain [32];
   logic [5:0]  mac_fill;
   logic [63:0] mac_len;
   logic        mac_open;

   tag_beat_type pending_tag [$];
   tag_beat_type want;
   stim_row_type stim_rows [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          src_idle_pct = 0;
   int          sink_stall_pct = 0;
   bit          cfg_settle = 1'b1;

   keyed_feistel_mac u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tag_byte  (rsp_tag_byte),
      .rsp_tag_last  (rsp_tag_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [7:0] key_at(input int idx);
      int eff;
      int j;
      eff = (cfg_key_len == 0 || cfg_key_len > 32) ? 32 : int'(cfg_key_len);
      j = idx % eff;
      return cfg_key[j / 8][8 * (j % 8) +: 8];
   endfunction

   function automatic void mac_round(input int rnd);
      logic [7:0] f [16];
      logic [7:0] k;
      logic [7:0] x;
      logic [7:0] lo;
      int v;
      int s;
      for (int i = 0; i < 16; i++) begin
         k = key_at(i);
         v = int'(mac_chain[16 + i] ^ k);
         s = (rnd + i) % 8;
         x = 8'((v << s) | (v >> (8 - s)));
         x = x & AND_MASK[(i + 7 * rnd) % 32];
         x = x | OR_MASK[(i + 11 * rnd) % 32];
         f[i] = x ^ mac_chain[16 + (i + rnd + 1) % 16] ^ k;
      end
      // right half moves left, left half xor F becomes the new right half
      for (int i = 0; i < 16; i++) begin
         lo = mac_chain[i];
         mac_chain[i] = mac_chain[16 + i];
         mac_chain[16 + i] = lo ^ f[i];
      end
   endfunction

   function automatic void mac_rounds(input int first);
      for (int r = 0; r < int'(cfg_rounds); r++)
         mac_round(first + r);
   endfunction

   function automatic void mac_absorb(input logic [7:0] data, input logic has,
                                      input logic last, input int n_typed,
                                      input logic [63:0] typed);
      int n;
      tag_beat_type beat;
      if (!has && !last)
         return;
      if (!mac_open) begin
         for (int i = 0; i < 32; i++)
            mac_chain[i] = key_at(i);
         mac_fill = '0;
         mac_len  = '0;
         mac_open = 1'b1;
      end
      if (has) begin
         mac_chain[mac_fill[4:0]] ^= data;
         mac_fill++;
         mac_len++;
         if (mac_fill == 6'd32) begin
            mac_rounds(0);
            mac_fill = '0;
         end
      end
      if (!last)
         return;
      if (mac_fill != 0)
         mac_rounds(0);
      for (int i = 0; i < 8; i++)
         mac_chain[i] ^= mac_len[56 - 8 * i +: 8];
      mac_rounds(int'(cfg_rounds));
      mac_fill = '0;
      mac_len  = '0;
      mac_open = 1'b0;
      n = (cfg_tag_len > 32) ? 32 : int'(cfg_tag_len);
      for (int i = 0; i < n; i++) begin
         beat.tag  = (i < n_typed) ? typed[8 * i +: 8] : mac_chain[i];
         beat.last = (i == n - 1);
         pending_tag.push_back(beat);
      end
   endfunction

   // entered and left just after a falling edge
   task automatic send_item(input logic [7:0] data, input logic has, input logic last,
                            input int n_typed, input logic [63:0] typed);
      while ($urandom_range(99, 0) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_has_byte  <= has;
      req_last      <= last;
      do @(posedge clock); while (!req_ready);
      mac_absorb(data, has, last, n_typed, typed);
      cfg_settle = 1'b1;
      @(negedge clock);
   endtask

   // registers change only with no tags pending and the round unit settled
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      req_valid <= 1'b0;
      if (cfg_settle) begin
         while (pending_tag.size() != 0)
            @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
         cfg_settle = 1'b0;
      end
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         kfm_pkg::CSR_KEY_A:      cfg_key[0] = val;
         kfm_pkg::CSR_KEY_B:      cfg_key[1] = val;
         kfm_pkg::CSR_KEY_C:      cfg_key[2] = val;
         kfm_pkg::CSR_KEY_D:      cfg_key[3] = val;
         kfm_pkg::CSR_KEY_LENGTH: cfg_key_len = val[6:0];
         kfm_pkg::CSR_ROUNDS:     cfg_rounds = val[3:0];
         kfm_pkg::CSR_TAG_LENGTH: cfg_tag_len = val[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tag.size() == 0) begin
            $error("unexpected tag transaction: tag_byte %02h tag_last %0b",
                   rsp_tag_byte, rsp_tag_last);
            fail_count++;
         end else begin
            want = pending_tag.pop_front();
            if (rsp_tag_byte !== want.tag) begin
               $error("tag_byte mismatch: expected %02h, actual %02h",
                      want.tag, rsp_tag_byte);
               fail_count++;
            end
            if (rsp_tag_last !== want.last) begin
               $error("tag_last mismatch: expected %0b, actual %0b",
                      want.last, rsp_tag_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("keyed_feistel_mac regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int len;
      int sent;
      bit tail_on_byte;
      logic [6:0] klen;
      logic [3:0] rcount;
      logic [5:0] tlen;
      logic [63:0] kw;

      req_valid     = 1'b0;
      req_data_byte = '0;
      req_has_byte  = 1'b0;
      req_last      = 1'b0;
      csr_we        = 1'b0;
      csr_index     = kfm_pkg::CSR_KEY_A;
      csr_wdata     = '0;
      foreach (cfg_key[i])
         cfg_key[i] = '0;
      cfg_key_len = 7'd32;
      cfg_rounds  = 4'd8;
      cfg_tag_len = 6'd32;
      foreach (mac_chain[i])
         mac_chain[i] = '0;
      mac_fill = '0;
      mac_len  = '0;
      mac_open = 1'b0;

      // reset settings: zero key, 8 rounds, 32-byte tag
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'hFF, 1'b1, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            0, 64'h0});
      // key byte j = j, no rounds: tags are the key with message bytes and length folded in
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_A, 64'h0706050403020100,
                            8'h0, 1'b0, 1'b0, 0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_B, 64'h0F0E0D0C0B0A0908,
                            8'h0, 1'b0, 1'b0, 0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_C, 64'h1716151413121110,
                            8'h0, 1'b0, 1'b0, 0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_D, 64'h1F1E1D1C1B1A1918,
                            8'h0, 1'b0, 1'b0, 0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_ROUNDS, 64'd0, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_TAG_LENGTH, 64'd8, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            8, 64'h0706050403020100});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'hFF, 1'b1, 1'b1,
                            8, 64'h06060504030201FF});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h5A, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b1, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h80, 1'b1, 1'b1,
                            8, 64'h0506050403028100});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_LENGTH, 64'd3, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            8, 64'h0100020100020100});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_LENGTH, 64'd0, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            8, 64'h0706050403020100});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_LENGTH, 64'd64, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            8, 64'h0706050403020100});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_LENGTH, 64'd1, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h3C, 1'b1, 1'b1,
                            8, 64'h010000000000003C});
      // zero tag length: message closes silently
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_TAG_LENGTH, 64'd0, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_LENGTH, 64'd32, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_ROUNDS, 64'd15, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_TAG_LENGTH, 64'd63, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'hA5, 1'b1, 1'b1,
                            0, 64'h0});
      // round count changes with a message open
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h11, 1'b1, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_ROUNDS, 64'd1, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'hEE, 1'b1, 1'b1,
                            0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_KEY_A, 64'hFFFF_FFFF_FFFF_FFFF,
                            8'h0, 1'b0, 1'b0, 0, 64'h0});
      stim_rows.push_back('{ROW_REG, kfm_pkg::CSR_TAG_LENGTH, 64'd32, 8'h0, 1'b0, 1'b0,
                            0, 64'h0});
      stim_rows.push_back('{ROW_ITEM, kfm_pkg::CSR_KEY_A, 64'h0, 8'h00, 1'b0, 1'b1,
                            0, 64'h0});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[r]) begin
         if (stim_rows[r].kind == ROW_REG)
            write_reg(stim_rows[r].index, stim_rows[r].value);
         else
            send_item(stim_rows[r].data, stim_rows[r].has, stim_rows[r].last,
                      stim_rows[r].n_typed, stim_rows[r].typed);
      end

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
            default: begin src_idle_pct = 14; sink_stall_pct = 14; end
         endcase
         case (p)
            0: begin klen = 7'd1;  rcount = 4'd15; tlen = 6'd32; end
            1: begin klen = 7'd64; rcount = 4'd0;  tlen = 6'd1;  end
            2: begin klen = 7'd32; rcount = 4'd1;  tlen = 6'd17; end
            3: begin klen = 7'd7;  rcount = 4'd8;  tlen = 6'd32; end
            4: begin
               klen   = 7'($urandom_range(64, 1));
               rcount = 4'($urandom_range(15, 0));
               tlen   = 6'($urandom_range(32, 1));
            end
            5: begin klen = 7'd16; rcount = 4'd15; tlen = 6'd32; end
            6: begin klen = 7'd33; rcount = 4'd3;  tlen = 6'd63; end
            default: begin klen = 7'd31; rcount = 4'd15; tlen = 6'd32; end
         endcase
         for (int w = 0; w < 4; w++) begin
            if (p == 1)
               kw = '1;
            else if (p == 2)
               kw = '0;
            else
               kw = {$urandom(), $urandom()};
            write_reg(kfm_pkg::CSR_KEY_A + 3'(w), kw);
         end
         write_reg(kfm_pkg::CSR_KEY_LENGTH, 64'(klen));
         write_reg(kfm_pkg::CSR_ROUNDS, 64'(rcount));
         write_reg(kfm_pkg::CSR_TAG_LENGTH, 64'(tlen));

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // block-boundary lengths show up often
            case ($urandom_range(9, 0))
               0: len = 0;
               1: len = 32;
               2: len = 64;
               3: len = 31;
               4: len = 33;
               default: len = $urandom_range(20, 1);
            endcase
            tail_on_byte = (len != 0) && ($urandom_range(1, 0) == 1);
            for (int b = 0; b < len; b++) begin
               if ($urandom_range(7, 0) == 0)
                  send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, 0, 64'h0);
               send_item(8'($urandom_range(255, 0)), 1'b1,
                         tail_on_byte && (b == len - 1), 0, 64'h0);
               sent++;
            end
            if (!tail_on_byte) begin
               send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, 0, 64'h0);
               sent++;
            end
         end
         // sometimes leave a message open across the next register writes
         if ($urandom_range(2, 0) == 0) begin
            len = $urandom_range(5, 1);
            for (int b = 0; b < len; b++)
               send_item(8'($urandom_range(255, 0)), 1'b1, 1'b0, 0, 64'h0);
         end
         req_valid <= 1'b0;
      end

      // close any message still open
      send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, 0, 64'h0);
      req_valid <= 1'b0;
      while (pending_tag.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("keyed_feistel_mac regression: pass");
      else
         $display("keyed_feistel_mac regression: fail");
      $finish;
   end

endmodule
